// File: hw/rtl/ffba_pkg.sv
// Package holding the constants, codes and request and response types of the block allocator.
package ffba_pkg;

  localparam int HEAP_BYTES_DEF   = 1048576;
  localparam int HEADER_BYTES_DEF = 24;
  localparam int ALIGN_BYTES_DEF  = 8;
  localparam int MAX_BLOCKS_DEF   = 64;

  localparam int OFF_W  = 20;
  localparam int REQ_W  = 21;
  localparam int SIZE_W = 26;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOFIT  = 3'd1;
  localparam logic [2:0] ST_ZERO   = 3'd2;
  localparam logic [2:0] ST_DOUBLE = 3'd3;
  localparam logic [2:0] ST_BADOFF = 3'd4;

  typedef struct packed {
    logic [1:0]       operation;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] payload_offset;
    logic             null_ref;
  } ffba_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    logic [2:0]       status;
    logic             moved;
  } ffba_rsp_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [SIZE_W-1:0] wr_bytes;
    logic             wr_free;
  } ffba_mem_cmd_t;

endpackage

// File: hw/rtl/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator with split and coalesce.
//   channel  direction  payload     handshake
//   in_      input      ffba_req_t  in_valid / in_stall
//   out_     output     ffba_rsp_t  out_valid / out_stall
// A request walks the table entry by entry; a split shifts the later entries up, and a
// free or a moved realloc ends with a merge pass over the whole table.
// The table memory has one registered read port and one write port.
// Reset is synchronous and leaves one free block covering the whole heap.
// A stalled response holds; the next request waits until it has been taken.
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ffba_req_t in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ffba_rsp_t out_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);

  ffba_mem_cmd_t     cmd;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [SIZE_W-1:0] rd_bytes;
  logic              rd_free;

  ffba_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES), .ALIGN_BYTES(ALIGN_BYTES)
  ) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cmd, .wr_addr, .rd_addr, .rd_bytes, .rd_free
  );

  ffba_table #(
    .MAX_BLOCKS(MAX_BLOCKS), .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)
  ) u_table (
    .clk, .rst_n, .cmd, .wr_addr, .rd_addr, .rd_bytes, .rd_free
  );

endmodule

// File: hw/rtl/ffba_table.sv
// Block table memory holding the payload size and free mark of each block.
module ffba_table import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int IDX_W        = $clog2(MAX_BLOCKS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ffba_mem_cmd_t     cmd,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [SIZE_W-1:0] rd_bytes,
  output logic              rd_free
);

  logic [SIZE_W:0] mem [MAX_BLOCKS];
  logic            init_r;
  logic [SIZE_W:0] rd_r;

  // Entry 0 reads as the reset block until it has been written once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b1;
    end else if (cmd.wr_en && wr_addr == '0) begin
      init_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= {cmd.wr_free, cmd.wr_bytes};
    end
    if (cmd.rd_en) begin
      if (init_r && rd_addr == '0) begin
        rd_r <= {1'b1, SIZE_W'(HEAP_BYTES - HEADER_BYTES)};
      end else begin
        rd_r <= mem[rd_addr];
      end
    end
  end

  assign rd_bytes = rd_r[SIZE_W-1:0];
  assign rd_free  = rd_r[SIZE_W];

endmodule

// File: hw/rtl/ffba_ctrl.sv
// Sequencer that walks, splits and merges the block table for each request.
module ffba_ctrl import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF,
  parameter int IDX_W        = $clog2(MAX_BLOCKS),
  parameter int CNT_W        = $clog2(MAX_BLOCKS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ffba_req_t         in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ffba_rsp_t         out_data,
  output ffba_mem_cmd_t     cmd,
  output logic [IDX_W-1:0]  wr_addr,
  output logic [IDX_W-1:0]  rd_addr,
  input  logic [SIZE_W-1:0] rd_bytes,
  input  logic              rd_free
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FIND   = 4'd1;
  localparam logic [3:0] S_FINDW  = 4'd2;
  localparam logic [3:0] S_FIT    = 4'd3;
  localparam logic [3:0] S_FITW   = 4'd4;
  localparam logic [3:0] S_SHIFT  = 4'd5;
  localparam logic [3:0] S_SHIFTW = 4'd6;
  localparam logic [3:0] S_GRANT  = 4'd7;
  localparam logic [3:0] S_MERGE  = 4'd8;
  localparam logic [3:0] S_MERGEW = 4'd9;
  localparam logic [3:0] S_FLUSH  = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  localparam logic [SIZE_W-1:0] HDR   = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] ALGN  = SIZE_W'(ALIGN_BYTES);
  localparam logic [SIZE_W-1:0] AMASK = ~(SIZE_W'(ALIGN_BYTES) - SIZE_W'(1));
  localparam logic [CNT_W-1:0]  MAXC  = CNT_W'(MAX_BLOCKS);

  logic [3:0]        state_r, state_nxt;
  ffba_req_t         req_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  w_r, w_nxt;
  logic [SIZE_W-1:0] pos_r, pos_nxt;
  logic [SIZE_W-1:0] need_r;
  logic [SIZE_W-1:0] fit_bytes_r, fit_bytes_nxt;
  logic [CNT_W-1:0]  fit_idx_r, fit_idx_nxt;
  logic [SIZE_W-1:0] fit_pos_r, fit_pos_nxt;
  logic              split_r, split_nxt;
  logic [CNT_W-1:0]  old_idx_r, old_idx_nxt;
  logic              realloc_r, realloc_nxt;
  logic [SIZE_W-1:0] acc_bytes_r, acc_bytes_nxt;
  logic              acc_free_r, acc_free_nxt;
  logic              acc_ok_r, acc_ok_nxt;
  logic              out_valid_r;
  ffba_rsp_t         out_r, out_nxt;
  logic              fin;
  logic              rd_cur_free;
  logic [SIZE_W-1:0] need_c;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign need_c    = (SIZE_W'(req_r.request_bytes) + ALGN - SIZE_W'(1)) & AMASK;
  assign rd_cur_free = rd_free || (realloc_r && i_r == old_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r  <= in_data;
    end
    if (state_r == S_FIND || state_r == S_FIT) begin
      need_r <= need_c;
    end
    i_r         <= i_nxt;
    w_r         <= w_nxt;
    pos_r       <= pos_nxt;
    fit_bytes_r <= fit_bytes_nxt;
    fit_idx_r   <= fit_idx_nxt;
    fit_pos_r   <= fit_pos_nxt;
    split_r     <= split_nxt;
    old_idx_r   <= old_idx_nxt;
    realloc_r   <= realloc_nxt;
    acc_bytes_r <= acc_bytes_nxt;
    acc_free_r  <= acc_free_nxt;
    acc_ok_r    <= acc_ok_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    pos_nxt       = pos_r;
    fit_bytes_nxt = fit_bytes_r;
    fit_idx_nxt   = fit_idx_r;
    fit_pos_nxt   = fit_pos_r;
    split_nxt     = split_r;
    old_idx_nxt   = old_idx_r;
    realloc_nxt   = realloc_r;
    acc_bytes_nxt = acc_bytes_r;
    acc_free_nxt  = acc_free_r;
    acc_ok_nxt    = acc_ok_r;
    out_nxt       = out_r;
    fin           = 1'b0;
    cmd           = '0;
    wr_addr       = '0;
    rd_addr       = i_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid && !out_valid_r) begin
          i_nxt       = '0;
          pos_nxt     = HDR;
          realloc_nxt = 1'b0;
          out_nxt     = '0;
          case (in_data.operation)
            OP_ALLOC: begin
              state_nxt = (in_data.request_bytes == '0) ? S_DONE : S_FIT;
              out_nxt.status = (in_data.request_bytes == '0) ? ST_ZERO : ST_OK;
            end
            OP_FREE: begin
              state_nxt = in_data.null_ref ? S_DONE : S_FIND;
            end
            OP_REALLOC: begin
              if (in_data.null_ref) begin
                state_nxt = (in_data.request_bytes == '0) ? S_DONE : S_FIT;
                out_nxt.status = (in_data.request_bytes == '0) ? ST_ZERO : ST_OK;
              end else begin
                state_nxt = S_FIND;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FIND: begin
        if (i_r >= count_r) begin
          out_nxt.status = ST_BADOFF;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_FINDW;
        end
      end
      S_FINDW: begin
        if (pos_r == SIZE_W'(req_r.payload_offset)) begin
          old_idx_nxt = i_r;
          if (rd_free) begin
            out_nxt.status = ST_DOUBLE;
            state_nxt      = S_DONE;
          end else if (req_r.operation == OP_FREE) begin
            out_nxt.result_offset = req_r.payload_offset;
            cmd.wr_en   = 1'b1;
            cmd.wr_free = 1'b1;
            cmd.wr_bytes = rd_bytes;
            wr_addr     = i_r[IDX_W-1:0];
            i_nxt       = '0;
            w_nxt       = '0;
            acc_ok_nxt  = 1'b0;
            state_nxt   = S_MERGE;
          end else if (rd_bytes >= SIZE_W'(req_r.request_bytes)) begin
            out_nxt.result_offset = req_r.payload_offset;
            state_nxt = S_DONE;
          end else begin
            realloc_nxt = 1'b1;
            i_nxt       = '0;
            pos_nxt     = HDR;
            state_nxt   = S_FIT;
          end
        end else begin
          pos_nxt   = pos_r + HDR + rd_bytes;
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_FIND;
        end
      end
      S_FIT: begin
        if (i_r >= count_r) begin
          out_nxt.status = ST_NOFIT;
          state_nxt      = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_FITW;
        end
      end
      S_FITW: begin
        if (rd_free && !(realloc_r && i_r == old_idx_r) && rd_bytes >= need_r) begin
          fit_idx_nxt   = i_r;
          fit_pos_nxt   = pos_r;
          fit_bytes_nxt = rd_bytes;
          if (rd_bytes >= need_r + HDR + ALGN && count_r < MAXC) begin
            split_nxt = 1'b1;
            i_nxt     = count_r - CNT_W'(1);
            count_nxt = count_r + CNT_W'(1);
            state_nxt = S_SHIFT;
          end else begin
            split_nxt = 1'b0;
            state_nxt = S_GRANT;
          end
        end else begin
          pos_nxt   = pos_r + HDR + rd_bytes;
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_FIT;
        end
      end
      S_SHIFT: begin
        if (i_r == fit_idx_r) begin
          cmd.wr_en    = 1'b1;
          cmd.wr_free  = 1'b1;
          cmd.wr_bytes = fit_bytes_r - need_r - HDR;
          wr_addr      = IDX_W'(fit_idx_r + CNT_W'(1));
          if (realloc_r && old_idx_r > fit_idx_r) begin
            old_idx_nxt = old_idx_r + CNT_W'(1);
          end
          state_nxt = S_GRANT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_SHIFTW;
        end
      end
      S_SHIFTW: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_free  = rd_free;
        cmd.wr_bytes = rd_bytes;
        wr_addr      = IDX_W'(i_r + CNT_W'(1));
        i_nxt        = i_r - CNT_W'(1);
        state_nxt    = S_SHIFT;
      end
      S_GRANT: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_free  = 1'b0;
        cmd.wr_bytes = split_r ? need_r : fit_bytes_r;
        wr_addr      = fit_idx_r[IDX_W-1:0];
        out_nxt.result_offset = fit_pos_r[OFF_W-1:0];
        if (realloc_r) begin
          out_nxt.moved = 1'b1;
          i_nxt      = '0;
          w_nxt      = '0;
          acc_ok_nxt = 1'b0;
          state_nxt  = S_MERGE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MERGE: begin
        if (i_r >= count_r) begin
          if (acc_ok_r) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_free  = acc_free_r;
            cmd.wr_bytes = acc_bytes_r;
            wr_addr      = w_r[IDX_W-1:0];
          end
          count_nxt = w_r + CNT_W'(acc_ok_r);
          state_nxt = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_MERGEW;
        end
      end
      S_MERGEW: begin
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_MERGE;
        if (acc_ok_r && acc_free_r && rd_cur_free) begin
          acc_bytes_nxt = acc_bytes_r + HDR + rd_bytes;
        end else begin
          if (acc_ok_r) begin
            cmd.wr_en    = 1'b1;
            cmd.wr_free  = acc_free_r;
            cmd.wr_bytes = acc_bytes_r;
            wr_addr      = w_r[IDX_W-1:0];
            w_nxt        = w_r + CNT_W'(1);
          end
          acc_ok_nxt    = 1'b1;
          acc_bytes_nxt = rd_bytes;
          acc_free_nxt  = rd_cur_free;
        end
      end
      S_FLUSH: state_nxt = S_DONE;
      S_DONE: begin
        if (out_nxt.status != ST_OK) begin
          out_nxt.result_offset = '0;
          out_nxt.moved         = 1'b0;
        end
        fin       = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
